>>> sv/stat_pkg.sv
// Shared types and constants for the sparse triplet accumulate table.
package stat_pkg;

    localparam int ENTRIES_DEF   = 1024;
    localparam int CELL_BITS_DEF = 20;
    localparam int CELL_W        = 20;
    localparam int VALUE_W       = 64;
    localparam int RIDX_W        = 10;
    localparam int CNT_W         = 11;

    typedef enum logic [1:0] {
        OP_ASSEMBLE = 2'd0,
        OP_ADD      = 2'd1,
        OP_CLEAR    = 2'd2,
        OP_READ     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_CLR,
        S_READ_CMP
    } t_state;

    typedef struct packed {
        logic [1:0]                 req_type;
        logic [CELL_W-1:0]          row;
        logic [CELL_W-1:0]          column;
        logic signed [VALUE_W-1:0]  value;
        logic [RIDX_W-1:0]          read_index;
    } t_req;

    typedef struct packed {
        logic [1:0]                 status;
        logic [RIDX_W-1:0]          entry_index;
        logic                       was_new;
        logic [CELL_W-1:0]          entry_row;
        logic [CELL_W-1:0]          entry_column;
        logic signed [VALUE_W-1:0]  entry_value;
        logic [CNT_W-1:0]           entry_count;
    } t_rsp;

    // Classified work item handed from the front end to the engine.
    typedef struct packed {
        t_op                        op;
        logic [CELL_W-1:0]          row;
        logic [CELL_W-1:0]          column;
        logic signed [VALUE_W-1:0]  value;
        logic [RIDX_W-1:0]          read_index;
    } t_work;

    function automatic logic [VALUE_W-1:0] sat_add(input logic [VALUE_W-1:0] a,
                                                   input logic [VALUE_W-1:0] b);
        logic [VALUE_W-1:0] s;
        s = a + b;
        if (a[VALUE_W-1] == b[VALUE_W-1] && s[VALUE_W-1] != a[VALUE_W-1]) begin
            return a[VALUE_W-1] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                : {1'b0, {(VALUE_W-1){1'b1}}};
        end
        return s;
    endfunction

endpackage

>>> sv/stat_front.sv
// Front end: accepts transactions, masks the key and queues classified work.
module stat_front import stat_pkg::*; #(
    parameter int CELL_BITS = CELL_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_req  i_req,
    output logic  o_work_valid,
    output t_work o_work,
    input  logic  i_pop
);
    localparam int KB = (CELL_BITS < CELL_W) ? CELL_BITS : CELL_W;
    localparam logic [CELL_W-1:0] KMASK = CELL_W'((64'd1 << KB) - 64'd1);

    t_work      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push;
    t_work      cls;

    assign o_stall      = (r_cnt == 2'd2);
    assign push         = i_valid && !o_stall;
    assign o_work_valid = (r_cnt != 2'd0);
    assign o_work       = r_q[r_rp];

    always_comb begin
        cls.op         = t_op'(i_req.req_type);
        cls.row        = i_req.row & KMASK;
        cls.column     = i_req.column & KMASK;
        cls.value      = i_req.value;
        cls.read_index = i_req.read_index;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= cls;
    end
endmodule

>>> sv/stat_back.sv
// Engine: key scan, saturating accumulate, clear sweep and entry read.
module stat_back import stat_pkg::*; #(
    parameter int ENTRIES   = ENTRIES_DEF,
    parameter int CELL_BITS = CELL_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_work_valid,
    input  t_work i_work,
    output logic  o_pop,
    output logic  o_valid,
    input  logic  i_stall,
    output t_rsp  o_rsp
);
    localparam int KB = (CELL_BITS < CELL_W) ? CELL_BITS : CELL_W;
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int XW = (CW > RIDX_W) ? CW : RIDX_W;

    logic [2*KB-1:0]    mem_key [ENTRIES];
    logic [VALUE_W-1:0] mem_val [ENTRIES];

    t_state            r_state, n_state;
    t_work             r_work, n_work;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_used, n_used;
    t_rsp              r_out, n_out;
    logic              r_out_valid, n_out_valid;
    logic [2*KB-1:0]   r_key_q;
    logic [VALUE_W-1:0] r_val_q;

    logic              rd_en, key_we, val_we;
    logic [IW-1:0]     rd_addr, wr_addr;
    logic [2*KB-1:0]   key_wd;
    logic [VALUE_W-1:0] val_wd, sum;
    logic [2*KB-1:0]   work_key;
    logic              hit, read_ok;

    assign work_key = {r_work.row[KB-1:0], r_work.column[KB-1:0]};
    assign hit      = (r_key_q == work_key);
    assign read_ok  = XW'(r_work.read_index) < XW'(r_used);
    assign sum      = sat_add(r_val_q, r_work.value);
    assign o_valid  = r_out_valid;
    assign o_rsp    = r_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_work_valid && !r_out_valid) n_state = S_START;
            S_START: begin
                unique case (r_work.op)
                    OP_ASSEMBLE, OP_ADD: n_state = S_SCAN_RD;
                    OP_CLEAR:            n_state = S_CLR;
                    OP_READ:             n_state = read_ok ? S_READ_CMP : S_IDLE;
                    default:             n_state = S_IDLE;
                endcase
            end
            S_SCAN_RD:  n_state = (r_idx == r_used) ? S_IDLE : S_SCAN_CMP;
            S_SCAN_CMP: n_state = hit ? S_IDLE : S_SCAN_RD;
            S_CLR:      if (r_idx == r_used) n_state = S_IDLE;
            S_READ_CMP: n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop       = 1'b0;
        n_work      = r_work;
        n_idx       = r_idx;
        n_used      = r_used;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;
        rd_en       = 1'b0;
        rd_addr     = r_idx[IW-1:0];
        key_we      = 1'b0;
        val_we      = 1'b0;
        wr_addr     = r_idx[IW-1:0];
        key_wd      = work_key;
        val_wd      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_work_valid && !r_out_valid) begin
                    o_pop  = 1'b1;
                    n_work = i_work;
                    n_idx  = '0;
                end
            end
            S_START: begin
                if (r_work.op == OP_READ) begin
                    if (read_ok) begin
                        rd_en   = 1'b1;
                        rd_addr = IW'(r_work.read_index);
                    end else begin
                        n_out       = '0;
                        n_out.status      = ST_MISS;
                        n_out.entry_count = CNT_W'(r_used);
                        n_out_valid = 1'b1;
                    end
                end
            end
            S_SCAN_RD: begin
                if (r_idx == r_used) begin
                    n_out = '0;
                    if (r_work.op == OP_ADD) begin
                        n_out.status = ST_MISS;
                    end else if (r_used == CW'(ENTRIES)) begin
                        n_out.status = ST_FULL;
                    end else begin
                        key_we  = 1'b1;
                        val_we  = 1'b1;
                        wr_addr = r_used[IW-1:0];
                        val_wd  = r_work.value;
                        n_used  = r_used + 1'b1;
                        n_out.status       = ST_OK;
                        n_out.entry_index  = RIDX_W'(r_used);
                        n_out.was_new      = 1'b1;
                        n_out.entry_row    = CELL_W'(r_work.row[KB-1:0]);
                        n_out.entry_column = CELL_W'(r_work.column[KB-1:0]);
                        n_out.entry_value  = r_work.value;
                    end
                    n_out.entry_count = CNT_W'(n_used);
                    n_out_valid = 1'b1;
                end else begin
                    rd_en = 1'b1;
                end
            end
            S_SCAN_CMP: begin
                if (hit) begin
                    val_we = 1'b1;
                    val_wd = sum;
                    n_out  = '0;
                    n_out.status       = ST_OK;
                    n_out.entry_index  = RIDX_W'(r_idx);
                    n_out.entry_row    = CELL_W'(r_work.row[KB-1:0]);
                    n_out.entry_column = CELL_W'(r_work.column[KB-1:0]);
                    n_out.entry_value  = sum;
                    n_out.entry_count  = CNT_W'(r_used);
                    n_out_valid = 1'b1;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_CLR: begin
                if (r_idx == r_used) begin
                    n_out = '0;
                    n_out.status      = ST_OK;
                    n_out.entry_count = CNT_W'(r_used);
                    n_out_valid = 1'b1;
                end else begin
                    val_we = 1'b1;
                    n_idx  = r_idx + 1'b1;
                end
            end
            S_READ_CMP: begin
                n_out = '0;
                n_out.status       = ST_OK;
                n_out.entry_index  = r_work.read_index;
                n_out.entry_row    = CELL_W'(r_key_q[2*KB-1:KB]);
                n_out.entry_column = CELL_W'(r_key_q[KB-1:0]);
                n_out.entry_value  = r_val_q;
                n_out.entry_count  = CNT_W'(r_used);
                n_out_valid = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (key_we) mem_key[wr_addr] <= key_wd;
        if (val_we) mem_val[wr_addr] <= val_wd;
        if (rd_en) begin
            r_key_q <= mem_key[rd_addr];
            r_val_q <= mem_val[rd_addr];
        end
    end
endmodule

>>> sv/sparse_triplet_accumulate_table_top.sv
// Top level of the sparse triplet accumulate table.
// The engine takes one transaction at a time. Assemble and add read and compare stored keys in
// order until a match or the end of the used entries; clear sweeps the used values to zero;
// read fetches one entry, or answers a bad index with a miss status. New work is taken only
// once the previous result has left the output register, and the linear key scan sets the pace.
// Reset: synchronous, active low; clears the entry count, queue and output valid.
module sparse_triplet_accumulate_table_top import stat_pkg::*; #(
    parameter int ENTRIES   = ENTRIES_DEF,
    parameter int CELL_BITS = CELL_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);
    // The front end masks each key to CELL_BITS and holds up to two queued
    // transactions, so the upstream side can keep sending while the engine scans until the queue is full.
    logic  work_valid;
    t_work work;
    logic  pop;

    stat_front #(.CELL_BITS(CELL_BITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req        (i_req),
        .o_work_valid (work_valid),
        .o_work       (work),
        .i_pop        (pop)
    );

    // The engine keeps keys and values in memories filled in order of first
    // appearance and drives a registered result toward the downstream side.
    stat_back #(.ENTRIES(ENTRIES), .CELL_BITS(CELL_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work_valid (work_valid),
        .i_work       (work),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_rsp        (o_rsp)
    );
endmodule

>>> sv/stat_checker.sv
// Port-level checker for the sparse triplet accumulate table, with its bind.
module stat_checker import stat_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input t_req i_req,
    input logic o_valid,
    input logic i_stall,
    input t_rsp o_rsp
);
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid) else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_rsp)) else $error("result changed while stalled");

    a_hold_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_req))
        else $error("request changed while stalled");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.status != ST_OK |-> o_rsp.entry_value == '0 &&
        !o_rsp.was_new && o_rsp.entry_index == '0) else $error("failed result not zero");

    a_new_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.was_new |-> o_rsp.status == ST_OK && o_rsp.entry_count != '0)
        else $error("new entry with bad status");
endmodule

bind sparse_triplet_accumulate_table_top stat_checker u_stat_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_req   (i_req),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_rsp   (o_rsp)
);
